// File: rtl/core/edf_pkg.sv
// Shared types and constants for the EDF conflict-free grant scheduler.
// No dependencies; used by the compare unit and the top level.
package edf_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int MAX_REQUESTS_DEF     = 16;
  localparam int RESOURCE_ID_BITS_DEF = 8;

  // Fixed field widths of the request and result words.
  localparam int REQ_ID_W = 8;
  localparam int TIME_W   = 32;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANK,
    ST_CHECK,
    ST_EMIT_RD,
    ST_EMIT_PUT
  } state_t;

  // Verdict of the shared compare unit for one table entry against the held best.
  typedef struct packed {
    logic ahead;
    logic clash;
  } cmp_result_t;

endpackage

// File: rtl/core/edf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module edf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/edf_cmp.sv
// Shared compare unit: ranks a table entry against the held best entry and
// checks the two for a shared resource. Depends on edf_pkg.
module edf_cmp #(
  parameter int RES_W = edf_pkg::RESOURCE_ID_BITS_DEF
) (
  input  logic                      deadline_mode,
  input  logic [edf_pkg::TIME_W-1:0] cand_deadline,
  input  logic [edf_pkg::TIME_W-1:0] cand_arrival,
  input  logic [RES_W-1:0]          cand_left,
  input  logic [RES_W-1:0]          cand_right,
  input  logic [edf_pkg::TIME_W-1:0] best_deadline,
  input  logic [edf_pkg::TIME_W-1:0] best_arrival,
  input  logic [RES_W-1:0]          best_left,
  input  logic [RES_W-1:0]          best_right,
  output edf_pkg::cmp_result_t      result
);

  always_comb begin
    // Rank: deadline first when enabled and different, else arrival order
    if (deadline_mode && (cand_deadline != best_deadline)) begin
      result.ahead = cand_deadline < best_deadline;
    end else begin
      result.ahead = cand_arrival < best_arrival;
    end

    // Clash: any of the four resource pairings match
    result.clash = (cand_left == best_left) || (cand_left == best_right) ||
                   (cand_right == best_left) || (cand_right == best_right);
  end

endmodule

// File: rtl/core/edf_conflict_free_grant_scheduler_top.sv
// Top level of the EDF conflict-free grant scheduler: sequencer, flag vectors,
// output register. Depends on edf_pkg, edf_ram and edf_cmp.
//
// Usage: request words enter on in_valid/in_ready, one per cycle while the
// block is loading. Each is stored in the entry table (words beyond
// MAX_REQUESTS are dropped). A word with last_request set starts the grant
// pass; in_ready stays low until every result of the set has been handed to
// the output register. The pass runs n rounds over the n stored entries; each
// round scans the table once to pick the best open entry and once to test it
// against the granted ones, both through one compare unit and one RAM read
// port. Results leave on out_valid/out_ready in load order, each read from the
// table, then loaded into the output register; last_result marks the final
// one. A stalled receiver holds the output register and the block waits on
// it; the last result of a set may still wait there while the next set loads.
// The user writes deadline_mode through cfg_write_en/cfg_write_data while idle;
// the block does not enforce this. Synchronous reset empties the table, drops
// any pending result and sets deadline_mode to 1; no clearing pass.
module edf_conflict_free_grant_scheduler_top #(
  parameter int MAX_REQUESTS     = edf_pkg::MAX_REQUESTS_DEF,
  parameter int RESOURCE_ID_BITS = edf_pkg::RESOURCE_ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic                         cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [edf_pkg::REQ_ID_W-1:0] requester_id,
  input  logic [7:0]                   left_resource,
  input  logic [7:0]                   right_resource,
  input  logic [edf_pkg::TIME_W-1:0]   deadline,
  input  logic [edf_pkg::TIME_W-1:0]   arrival_seqno,
  input  logic                         last_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [edf_pkg::REQ_ID_W-1:0] granted_requester,
  output logic                         granted,
  output logic                         last_result
);

  localparam int IDX_W  = $clog2(MAX_REQUESTS);
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int RES_W  = RESOURCE_ID_BITS;
  localparam int ID_W   = edf_pkg::REQ_ID_W;
  localparam int T_W    = edf_pkg::TIME_W;
  // Word layout, low to high: requester, left, right, deadline, arrival
  localparam int LEFT_LO  = ID_W;
  localparam int RIGHT_LO = LEFT_LO + RES_W;
  localparam int DL_LO    = RIGHT_LO + RES_W;
  localparam int ARR_LO   = DL_LO + T_W;
  localparam int WORD_W   = ARR_LO + T_W;

  edf_pkg::state_t      state, state_next;
  edf_pkg::cmp_result_t cmp;

  logic                    deadline_mode;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        round;
  logic [CNT_W-1:0]        scan_cnt;
  logic [IDX_W-1:0]        data_idx;
  logic                    data_vld;
  logic [IDX_W-1:0]        emit_idx;
  logic [MAX_REQUESTS-1:0] considered;
  logic [MAX_REQUESTS-1:0] selected;
  logic                    found;
  logic                    ok;
  logic [IDX_W-1:0]        best_idx;
  logic [T_W-1:0]          best_deadline;
  logic [T_W-1:0]          best_arrival;
  logic [RES_W-1:0]        best_left;
  logic [RES_W-1:0]        best_right;

  logic                    in_fire;
  logic                    wr_en;
  logic [WORD_W-1:0]       wr_data;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [WORD_W-1:0]       rd_data;
  logic                    scan_issue;
  logic                    data_last;
  logic                    round_last;
  logic                    emit_last;
  logic                    out_load;
  logic                    take;
  logic                    hit;
  logic [IDX_W-1:0]        best_idx_next;
  logic                    ok_next;

  // Entry table
  assign wr_data = {arrival_seqno, deadline, RES_W'(right_resource),
                    RES_W'(left_resource), requester_id};

  edf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_REQUESTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared rank and clash unit
  edf_cmp #(
    .RES_W (RES_W)
  ) u_cmp (
    .deadline_mode (deadline_mode),
    .cand_deadline (rd_data[DL_LO +: T_W]),
    .cand_arrival  (rd_data[ARR_LO +: T_W]),
    .cand_left     (rd_data[LEFT_LO +: RES_W]),
    .cand_right    (rd_data[RIGHT_LO +: RES_W]),
    .best_deadline (best_deadline),
    .best_arrival  (best_arrival),
    .best_left     (best_left),
    .best_right    (best_right),
    .result        (cmp)
  );

  // Scan bookkeeping
  assign in_fire    = in_valid && in_ready;
  assign data_last  = (CNT_W'(data_idx) + CNT_W'(1)) == count;
  assign round_last = (round + CNT_W'(1)) == count;
  assign emit_last  = (CNT_W'(emit_idx) + CNT_W'(1)) == count;

  // Entry decisions on the word read back this cycle
  assign take          = data_vld && !considered[data_idx] && (!found || cmp.ahead);
  assign best_idx_next = take ? data_idx : best_idx;
  assign hit           = data_vld && selected[data_idx] && cmp.clash;
  assign ok_next       = ok && !hit;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      edf_pkg::ST_LOAD: begin
        if (in_fire && last_request) begin
          state_next = edf_pkg::ST_RANK;
        end
      end
      edf_pkg::ST_RANK: begin
        if (data_vld && data_last) begin
          state_next = edf_pkg::ST_CHECK;
        end
      end
      edf_pkg::ST_CHECK: begin
        if (data_vld && data_last) begin
          state_next = round_last ? edf_pkg::ST_EMIT_RD : edf_pkg::ST_RANK;
        end
      end
      edf_pkg::ST_EMIT_RD: begin
        state_next = edf_pkg::ST_EMIT_PUT;
      end
      edf_pkg::ST_EMIT_PUT: begin
        if (out_load) begin
          state_next = emit_last ? edf_pkg::ST_LOAD : edf_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = edf_pkg::ST_LOAD;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = scan_cnt[IDX_W-1:0];
    out_load   = 1'b0;
    case (state)
      edf_pkg::ST_LOAD: begin
        in_ready = 1'b1;
      end
      edf_pkg::ST_RANK, edf_pkg::ST_CHECK: begin
        scan_issue = scan_cnt != count;
        rd_en      = scan_issue;
      end
      edf_pkg::ST_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = emit_idx;
      end
      edf_pkg::ST_EMIT_PUT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign wr_en = in_fire && (count != CNT_W'(MAX_REQUESTS));

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= edf_pkg::ST_LOAD;
      deadline_mode <= 1'b1;
      count         <= '0;
      round         <= '0;
      scan_cnt      <= '0;
      data_vld      <= 1'b0;
      emit_idx      <= '0;
      considered    <= '0;
      selected      <= '0;
      found         <= 1'b0;
      ok            <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      state    <= state_next;
      data_vld <= scan_issue;

      if (cfg_write_en) begin
        deadline_mode <= cfg_write_data;
      end

      // Restart the scan on every phase change
      if (state_next != state) begin
        scan_cnt <= '0;
      end else if (scan_issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end

      // Load and start of a grant pass
      if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      if (in_fire && last_request) begin
        considered <= '0;
        selected   <= '0;
        round      <= '0;
        found      <= 1'b0;
        emit_idx   <= '0;
      end

      // Ranking scan: track the best open entry
      if (state == edf_pkg::ST_RANK) begin
        if (take) begin
          found <= 1'b1;
        end
        if (data_vld && data_last) begin
          considered[best_idx_next] <= 1'b1;
          ok                        <= 1'b1;
        end
      end

      // Conflict scan: grant the best entry if nothing granted clashes
      if (state == edf_pkg::ST_CHECK && data_vld) begin
        ok <= ok_next;
        if (data_last) begin
          selected[best_idx] <= ok_next;
          round              <= round + CNT_W'(1);
          found              <= 1'b0;
        end
      end

      // Emit results in load order
      if (out_load) begin
        out_valid <= 1'b1;
        emit_idx  <= emit_idx + IDX_W'(1);
        if (emit_last) begin
          count <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Best-entry and output payload registers
  always_ff @(posedge clk) begin
    if (state == edf_pkg::ST_RANK && take) begin
      best_idx      <= data_idx;
      best_deadline <= rd_data[DL_LO +: T_W];
      best_arrival  <= rd_data[ARR_LO +: T_W];
      best_left     <= rd_data[LEFT_LO +: RES_W];
      best_right    <= rd_data[RIGHT_LO +: RES_W];
    end
    if (scan_issue) begin
      data_idx <= scan_cnt[IDX_W-1:0];
    end
    if (out_load) begin
      granted_requester <= rd_data[ID_W-1:0];
      granted           <= selected[emit_idx];
      last_result       <= emit_last;
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for edf_conflict_free_grant_scheduler_top: directed rows, then random
// request sets, each grant word checked against its row's expected value or an in-bench predictor.
// Depends on edf_pkg and the scheduler RTL only.
module tb_top;

  localparam int REQ_ID_W      = edf_pkg::REQ_ID_W;
  localparam int TIME_W        = edf_pkg::TIME_W;
  localparam int SLOTS         = edf_pkg::MAX_REQUESTS_DEF;
  localparam int RID_W         = edf_pkg::RESOURCE_ID_BITS_DEF;
  localparam int RANDOM_WORDS  = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam bit MODE_FIFO     = 1'b0;
  localparam bit MODE_EDF      = 1'b1;
  localparam bit TYPED         = 1'b1;
  localparam bit PREDICTED     = 1'b0;

  typedef enum logic [1:0] {MODE_KEEP, SET_FIFO, SET_EDF} mode_cmd_t;

  typedef struct packed {
    logic [REQ_ID_W-1:0] requester;
    logic [7:0]          left_res;
    logic [7:0]          right_res;
    logic [TIME_W-1:0]   deadline_ts;
    logic [TIME_W-1:0]   arrival_seq;
    logic                last;
  } req_word_t;

  typedef struct packed {
    logic [REQ_ID_W-1:0] requester;
    logic                granted;
    logic                last;
  } grant_word_t;

  typedef struct {
    mode_cmd_t cmd;
    req_word_t word;
    bit        typed;
    bit        exp_granted;
    bit        exp_last;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write_en;
  logic                cfg_write_data;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_ID_W-1:0] requester_id;
  logic [7:0]          left_resource;
  logic [7:0]          right_resource;
  logic [TIME_W-1:0]   deadline;
  logic [TIME_W-1:0]   arrival_seqno;
  logic                last_request;
  logic                out_valid;
  logic                out_ready;
  logic [REQ_ID_W-1:0] granted_requester;
  logic                granted;
  logic                last_result;

  // Predictor state: current mode, the set being loaded, grants still owed.
  bit          edf_mode;
  req_word_t   held_word [SLOTS];
  bit          held_typed [SLOTS];
  bit          held_granted [SLOTS];
  bit          held_last [SLOTS];
  int          held_count;
  grant_word_t pending_grants [$];
  stim_row_t   stim_rows [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          reset_done = 1'b0;

  edf_conflict_free_grant_scheduler_top dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .requester_id      (requester_id),
    .left_resource     (left_resource),
    .right_resource    (right_resource),
    .deadline          (deadline),
    .arrival_seqno     (arrival_seqno),
    .last_request      (last_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .granted_requester (granted_requester),
    .granted           (granted),
    .last_result       (last_result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit outranks(int a, int b);
    if (edf_mode && held_word[a].deadline_ts != held_word[b].deadline_ts)
      return held_word[a].deadline_ts < held_word[b].deadline_ts;
    return held_word[a].arrival_seq < held_word[b].arrival_seq;
  endfunction

  function automatic bit shares_resource(int a, int b);
    logic [RID_W-1:0] al, ar, bl, br;
    al = held_word[a].left_res[RID_W-1:0];
    ar = held_word[a].right_res[RID_W-1:0];
    bl = held_word[b].left_res[RID_W-1:0];
    br = held_word[b].right_res[RID_W-1:0];
    return al == bl || al == br || ar == bl || ar == br;
  endfunction

  // Greedy pass in rank order, then queue one grant word per held entry in load order
  function automatic void predict_grants();
    bit          considered [SLOTS];
    bit          selected [SLOTS];
    int          best;
    bit          ok;
    grant_word_t g;
    for (int i = 0; i < SLOTS; i++) begin
      considered[i] = 1'b0;
      selected[i]   = 1'b0;
    end
    for (int round = 0; round < held_count; round++) begin
      best = -1;
      for (int i = 0; i < held_count; i++)
        if (!considered[i] && (best < 0 || outranks(i, best))) best = i;
      considered[best] = 1'b1;
      ok = 1'b1;
      for (int i = 0; i < held_count; i++)
        if (selected[i] && shares_resource(best, i)) ok = 1'b0;
      selected[best] = ok;
    end
    for (int i = 0; i < held_count; i++) begin
      g.requester = held_word[i].requester;
      g.granted   = held_typed[i] ? held_granted[i] : selected[i];
      g.last      = held_typed[i] ? held_last[i] : (i == held_count - 1);
      pending_grants.push_back(g);
    end
    held_count = 0;
  endfunction

  // Store an accepted word; drop it once the table is full
  function automatic void take_word(req_word_t w, bit typed, bit eg, bit el);
    if (held_count < SLOTS) begin
      held_word[held_count]    = w;
      held_typed[held_count]   = typed;
      held_granted[held_count] = eg;
      held_last[held_count]    = el;
      held_count++;
    end
    if (w.last) predict_grants();
  endfunction

  function automatic void add_row(mode_cmd_t cmd, logic [7:0] id, logic [7:0] l,
                                  logic [7:0] r, logic [31:0] dl, logic [31:0] arr,
                                  logic last, bit typed, bit eg, bit el);
    stim_row_t row;
    row.cmd         = cmd;
    row.word        = {id, l, r, dl, arr, last};
    row.typed       = typed;
    row.exp_granted = eg;
    row.exp_last    = el;
    stim_rows.push_back(row);
  endfunction

  // Offer one request word, hold it until accepted, then maybe idle
  task automatic send_word(req_word_t w, bit typed, bit eg, bit el, bit eager);
    int gap;
    in_valid       <= 1'b1;
    requester_id   <= w.requester;
    left_resource  <= w.left_res;
    right_resource <= w.right_res;
    deadline       <= w.deadline_ts;
    arrival_seqno  <= w.arrival_seq;
    last_request   <= w.last;
    do @(posedge clk); while (!in_ready);
    take_word(w, typed, eg, el);
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all owed grants, let the block settle, then write deadline_mode
  task automatic write_mode(bit value);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    edf_mode = value;
  endtask

  // Receiver: ready bursts separated by random stalls
  initial begin
    int run, gap;
    out_ready <= 1'b0;
    wait (reset_done);
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Check each accepted grant word against the oldest owed one
  always @(posedge clk) begin
    grant_word_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.requester = granted_requester;
      got.granted   = granted;
      got.last      = last_result;
      if (pending_grants.size() == 0) begin
        note_error($sformatf("unexpected word: requester %02h granted %0b last %0b",
                             got.requester, got.granted, got.last));
      end else begin
        want = pending_grants.pop_front();
        if (got.requester !== want.requester)
          note_error($sformatf("granted_requester: expected %02h, got %02h",
                               want.requester, got.requester));
        if (got.granted !== want.granted)
          note_error($sformatf("granted (requester %02h): expected %0b, got %0b",
                               want.requester, want.granted, got.granted));
        if (got.last !== want.last)
          note_error($sformatf("last_result (requester %02h): expected %0b, got %0b",
                               want.requester, want.last, got.last));
      end
    end
  end

  // Stimulus
  initial begin
    int        set_size, sent, r, arr_style, base_arr;
    bit        narrow_res, narrow_time, eager;
    req_word_t w;

    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 1'b0;
    in_valid       <= 1'b0;
    requester_id   <= '0;
    left_resource  <= '0;
    right_resource <= '0;
    deadline       <= '0;
    arrival_seqno  <= '0;
    last_request   <= 1'b0;
    edf_mode   = MODE_EDF;
    held_count = 0;

    // Lone request: all-zero fields, same resource twice
    add_row(MODE_KEEP, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, TYPED,
            1'b1, 1'b1);
    // All-ones word loses on its shared resource to the earlier deadline
    add_row(MODE_KEEP, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, TYPED,
            1'b0, 1'b0);
    add_row(MODE_KEEP, 8'h01, 8'hFF, 8'h10, 32'h0000_0000, 32'h0000_0000, 1'b1, TYPED,
            1'b1, 1'b1);
    // Repeated requester, deadline tie broken by arrival
    add_row(MODE_KEEP, 8'h05, 8'h01, 8'h02, 32'd10, 32'd7, 1'b0, TYPED, 1'b0, 1'b0);
    add_row(MODE_KEEP, 8'h05, 8'h02, 8'h03, 32'd10, 32'd3, 1'b1, TYPED, 1'b1, 1'b1);
    // Exact tie goes to the earlier-loaded entry
    add_row(MODE_KEEP, 8'h20, 8'h30, 8'h31, 32'd5, 32'd5, 1'b0, TYPED, 1'b1, 1'b0);
    add_row(MODE_KEEP, 8'h21, 8'h31, 8'h32, 32'd5, 32'd5, 1'b1, TYPED, 1'b0, 1'b1);
    // FIFO mode ignores the urgent deadline
    add_row(SET_FIFO, 8'h60, 8'h70, 8'h71, 32'h0000_0000, 32'd9, 1'b0, TYPED, 1'b0, 1'b0);
    add_row(MODE_KEEP, 8'h61, 8'h71, 8'h72, 32'hFFFF_FFFF, 32'd1, 1'b1, TYPED, 1'b1, 1'b1);
    // Full table, then a dropped word that still carries last
    for (int i = 0; i <= SLOTS; i++)
      add_row(MODE_KEEP, 8'(128 + i), 8'(i), 8'(i + 1), 32'(100 - i), 32'(i), i == SLOTS,
              PREDICTED, 1'b0, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    // Directed rows
    foreach (stim_rows[i]) begin
      if (stim_rows[i].cmd == SET_FIFO) write_mode(MODE_FIFO);
      else if (stim_rows[i].cmd == SET_EDF) write_mode(MODE_EDF);
      send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].exp_granted,
                stim_rows[i].exp_last, 1'b0);
    end

    // Random sets: mostly well-formed, some overflowing the table
    write_mode(MODE_EDF);
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 4) == 0) write_mode($urandom_range(0, 1) != 0);
      r = $urandom_range(0, 99);
      if (r < 40) set_size = $urandom_range(1, 4);
      else if (r < 88) set_size = $urandom_range(5, SLOTS);
      else set_size = $urandom_range(SLOTS + 1, SLOTS + 4);
      narrow_res  = $urandom_range(0, 2) != 0;
      narrow_time = $urandom_range(0, 1) != 0;
      arr_style   = $urandom_range(0, 2);
      base_arr    = $urandom;
      eager       = $urandom_range(0, 3) == 0;
      for (int j = 0; j < set_size; j++) begin
        w.requester   = 8'($urandom_range(0, 255));
        w.left_res    = narrow_res ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        w.right_res   = narrow_res ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        if (!narrow_time) w.deadline_ts = $urandom;
        else if ($urandom_range(0, 1)) w.deadline_ts = $urandom_range(0, 3);
        else w.deadline_ts = 32'hFFFF_FFFF - $urandom_range(0, 3);
        if (arr_style == 0) w.arrival_seq = base_arr + j;
        else if (arr_style == 1) w.arrival_seq = $urandom_range(0, 3);
        else w.arrival_seq = $urandom;
        w.last = (j == set_size - 1);
        send_word(w, PREDICTED, 1'b0, 1'b0, eager);
      end
      sent += (set_size < SLOTS) ? set_size : SLOTS;
    end

    // Drain and let any stray word show up
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
